/* hdl/rile_pkg.sv */
// rile_pkg: shared types and constants for the register image layout expander
// depends on nothing; imported by register_image_layout_expander_unit and tb
`timescale 1ns / 1ps

package rile_pkg;

  // image size in dwords and the widths that follow from it
  localparam int unsigned IMAGE_DWORDS = 1024;
  localparam int unsigned IDX_W        = $clog2(IMAGE_DWORDS);
  localparam int unsigned POS_W        = $clog2(IMAGE_DWORDS + 1);

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(IMAGE_DWORDS);

  // register reset values
  localparam logic [31:0] RST_REGISTER_BASE = 32'h0000_0000;
  localparam logic [31:0] RST_LOAD_OPCODE   = 32'h1100_0000;
  localparam logic [31:0] RST_POSTED_BIT    = 32'h0020_0000;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_REGISTER_BASE = 2'd0,
    REG_LOAD_OPCODE   = 2'd1,
    REG_POSTED_BIT    = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] layout_byte;
    logic       start_of_layout;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] write_index;
    logic [31:0]      write_value;
    logic             end_of_layout;
    logic             overrun;
  } out_word_t;

endpackage

/* hdl/register_image_layout_expander_unit.sv */
// register_image_layout_expander_unit: decodes the compact layout stream into
// dword writes for a register-load image; uses rile_pkg for types and constants
`timescale 1ns / 1ps
// a result word is registered in the output register in the cycle after its layout byte is taken
// throughput: one layout byte per cycle while the input is not stalled; one decode pass between the decoder
//   state registers and the output register
// the input stalls only while a result sits in the output register and out_stall is high
// reset (synchronous, active low) clears decoder state and the output valid and loads
//   register_base 0, load_opcode 0x11000000 and posted_bit 0x00200000

module register_image_layout_expander_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rile_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rile_pkg::out_word_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rile_pkg::CFG_AW-1:0]   paddr,
  input  logic [rile_pkg::CFG_DW-1:0]   pwdata,
  output logic [rile_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import rile_pkg::*;

  logic [31:0] register_base_r;
  logic [31:0] load_opcode_r;
  logic [31:0] posted_bit_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             in_offsets_r, in_offsets_nxt;
  logic [5:0]       offsets_left_r, offsets_left_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic             finished_r, finished_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  logic     accept;
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign cfg_idx  = reg_idx_t'(paddr[3:2]);
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      register_base_r <= RST_REGISTER_BASE;
      load_opcode_r   <= RST_LOAD_OPCODE;
      posted_bit_r    <= RST_POSTED_BIT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_REGISTER_BASE: register_base_r <= pwdata;
        REG_LOAD_OPCODE:   load_opcode_r   <= pwdata;
        REG_POSTED_BIT:    posted_bit_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_REGISTER_BASE: prdata = register_base_r;
      REG_LOAD_OPCODE:   prdata = load_opcode_r;
      REG_POSTED_BIT:    prdata = posted_bit_r;
      default:           prdata = '0;
    endcase
  end

  // decode of one layout byte
  logic [POS_W-1:0] cur_pos;
  logic             cur_in_offsets;
  logic [5:0]       cur_left;
  logic [31:0]      cur_acc;
  logic             cur_finished;
  logic [7:0]       byte_in;
  logic [6:0]       step;
  logic [POS_W:0]   pos_sum;
  logic [POS_W-1:0] pos_adv;
  logic             emit;
  logic             is_end;
  logic [31:0]      emit_value;
  logic [31:0]      acc_shift;
  logic [31:0]      hdr_len;
  logic [5:0]       count;

  always_comb begin
    byte_in = in_data.layout_byte;
    count   = byte_in[5:0];

    // a start flag clears the decoder before this byte is looked at
    if (in_data.start_of_layout) begin
      cur_pos        = '0;
      cur_in_offsets = 1'b0;
      cur_left       = '0;
      cur_acc        = '0;
      cur_finished   = 1'b0;
    end else begin
      cur_pos        = pos_r;
      cur_in_offsets = in_offsets_r;
      cur_left       = offsets_left_r;
      cur_acc        = acc_r;
      cur_finished   = finished_r;
    end

    pos_nxt          = cur_pos;
    in_offsets_nxt   = cur_in_offsets;
    offsets_left_nxt = cur_left;
    acc_nxt          = cur_acc;
    finished_nxt     = cur_finished;

    acc_shift = {cur_acc[24:0], byte_in[6:0]};
    hdr_len   = {25'd0, count, 1'b0} - 32'd1;
    emit      = 1'b0;
    is_end    = 1'b0;
    emit_value = '0;
    step      = '0;

    if (cur_finished) begin
      // ended layout: byte is dropped
    end else if (cur_in_offsets) begin
      if (byte_in[7]) begin
        acc_nxt = acc_shift;
      end else begin
        emit             = 1'b1;
        emit_value       = register_base_r + {acc_shift[29:0], 2'b00};
        step             = 7'd2;
        acc_nxt          = '0;
        offsets_left_nxt = cur_left - 6'd1;
        if (offsets_left_nxt == 6'd0) begin
          in_offsets_nxt = 1'b0;
        end
      end
    end else if (byte_in == 8'd0) begin
      emit         = 1'b1;
      is_end       = 1'b1;
      finished_nxt = 1'b1;
    end else if (byte_in[7]) begin
      step = byte_in[6:0];
    end else begin
      emit       = 1'b1;
      emit_value = load_opcode_r | hdr_len | (byte_in[6] ? posted_bit_r : 32'd0);
      step       = 7'd1;
      if (count != 6'd0) begin
        in_offsets_nxt   = 1'b1;
        offsets_left_nxt = count;
        acc_nxt          = '0;
      end
    end

    // saturating position update
    pos_sum = {1'b0, cur_pos} + {{(POS_W-6){1'b0}}, step};
    pos_adv = (pos_sum > {1'b0, POS_LIMIT}) ? POS_LIMIT : pos_sum[POS_W-1:0];
    pos_nxt = pos_adv;

    out_data_nxt.write_value   = emit_value;
    out_data_nxt.end_of_layout = is_end;
    if (!is_end && (cur_pos >= POS_LIMIT)) begin
      out_data_nxt.overrun     = 1'b1;
      out_data_nxt.write_index = '0;
    end else begin
      out_data_nxt.overrun     = 1'b0;
      out_data_nxt.write_index = is_end ? '0 : cur_pos[IDX_W-1:0];
    end

    if (accept) begin
      out_valid_nxt = emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r          <= '0;
      in_offsets_r   <= 1'b0;
      offsets_left_r <= '0;
      acc_r          <= '0;
      finished_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        pos_r          <= pos_nxt;
        in_offsets_r   <= in_offsets_nxt;
        offsets_left_r <= offsets_left_nxt;
        acc_r          <= acc_nxt;
        finished_r     <= finished_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  // assertions
  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LIMIT)
    else $error("position past image size");

  a_offsets_left: assert property (@(posedge clk) disable iff (!rst_n)
    in_offsets_r |-> offsets_left_r != 6'd0)
    else $error("offset phase with no offsets left");

  a_overrun_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.overrun |-> out_data_r.write_index == '0)
    else $error("suppressed write carries an index");

  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.end_of_layout |->
      out_data_r.write_value == 32'd0 && !out_data_r.overrun)
    else $error("end word carries data");

  a_finished_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && finished_r && !in_data.start_of_layout |=> $stable(pos_r) && finished_r)
    else $error("decoder moved after end of layout");

endmodule

/* tb/tb.sv */
// tb: self-checking bench for register_image_layout_expander_unit
// drives layout bytes, APB register writes and random stalls; checks words against
// a behavioral model of the decoder kept here; depends on rile_pkg and the unit
`timescale 1ns / 1ps

module tb;
  import rile_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       sol;
    logic       typed;
    out_word_t  want;
  } layout_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_word_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  register_image_layout_expander_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // decoder model state and register copies
  int          image_pos;
  bit          in_offsets;
  logic [5:0]  offsets_left;
  logic [31:0] offset_acc;
  bit          finished;
  logic [31:0] reg_base, reg_opcode, reg_posted;

  out_word_t   expected_words[$];
  layout_row_t layout_rows[$];
  int          mismatches = 0;
  int          items_done = 0;
  int          send_idle_pct = 8;
  int          recv_idle_pct = 72;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  function automatic out_word_t image_write(input logic [31:0] v);
    out_word_t r;
    r = '0;
    r.write_value = v;
    if (image_pos >= IMAGE_DWORDS) r.overrun = 1'b1;
    else r.write_index = image_pos[IDX_W-1:0];
    return r;
  endfunction

  function automatic void move_ahead(input int n);
    image_pos = (image_pos + n > IMAGE_DWORDS) ? IMAGE_DWORDS : image_pos + n;
  endfunction

  task automatic expand_byte(input in_word_t w, output bit has, output out_word_t r,
                             output bit ignored);
    logic [7:0]  b;
    logic [31:0] hdr;
    b = w.layout_byte;
    has = 1'b0;
    r = '0;
    ignored = 1'b0;
    if (w.start_of_layout) begin
      image_pos = 0;
      in_offsets = 1'b0;
      offsets_left = '0;
      offset_acc = '0;
      finished = 1'b0;
    end
    if (finished) begin
      ignored = 1'b1;
    end else if (in_offsets) begin
      // every byte here is an offset group, zero included
      offset_acc = {offset_acc[24:0], b[6:0]};
      if (!b[7]) begin
        has = 1'b1;
        r = image_write(reg_base + {offset_acc[29:0], 2'b00});
        move_ahead(2);
        offset_acc = '0;
        offsets_left = offsets_left - 6'd1;
        if (offsets_left == 6'd0) in_offsets = 1'b0;
      end
    end else if (b == 8'h00) begin
      has = 1'b1;
      r.end_of_layout = 1'b1;
      finished = 1'b1;
    end else if (b[7]) begin
      move_ahead(int'(b[6:0]));
    end else begin
      // length field is 2*count-1, all ones for a zero count
      hdr = reg_opcode | ({25'd0, b[5:0], 1'b0} - 32'd1);
      if (b[6]) hdr = hdr | reg_posted;
      has = 1'b1;
      r = image_write(hdr);
      move_ahead(1);
      if (b[5:0] != 6'd0) begin
        in_offsets = 1'b1;
        offsets_left = b[5:0];
        offset_acc = '0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    if (mismatches < 40) $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
    mismatches++;
  endtask

  // offer a word, wait for it to be taken, then record what it should produce
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    bit        has, ignored;
    out_word_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    expand_byte(w, has, r, ignored);
    if (typed) expected_words.push_back(want);
    else if (has) expected_words.push_back(r);
    if (!ignored) items_done++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sol);
    send_word({b, sol}, 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_REGISTER_BASE: reg_base = v;
      REG_LOAD_OPCODE:   reg_opcode = v;
      REG_POSTED_BIT:    reg_posted = v;
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [7:0] b, input logic sol, input logic typed,
                         input int idx, input logic [31:0] val, input logic eol,
                         input logic ovr);
    layout_row_t row;
    row.b = b;
    row.sol = sol;
    row.typed = typed;
    row.want.write_index = idx[IDX_W-1:0];
    row.want.write_value = val;
    row.want.end_of_layout = eol;
    row.want.overrun = ovr;
    layout_rows.push_back(row);
  endtask

  // one well-formed layout with random content, sometimes cut short
  task automatic send_layout();
    int   segs, cnt, nb;
    bit   skippy;
    logic posted;
    skippy = ($urandom_range(0, 9) == 0);
    segs = skippy ? $urandom_range(8, 20) : $urandom_range(1, 6);
    for (int s = 0; s < segs; s++) begin
      if ($urandom_range(0, 99) < (skippy ? 60 : 15)) begin
        send_byte({1'b1, 7'($urandom)}, s == 0);
      end else begin
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 4);
        // count zero without the posted bit would be the end byte
        posted = (cnt == 0) ? 1'b1 : 1'($urandom);
        send_byte({1'b0, posted, 6'(cnt)}, s == 0);
        for (int k = 0; k < cnt; k++) begin
          nb = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
          for (int j = 1; j <= nb; j++) send_byte({j < nb, 7'($urandom)}, 1'b0);
        end
      end
    end
    if ($urandom_range(0, 9) != 0) send_byte(8'h00, 1'b0);
  endtask

  // receiver stalls; a long hold-off is counted out here on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 60;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_out
    out_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with nothing pending", 64'd0, 64'(out_data));
      end else begin
        want = expected_words.pop_front();
        if (out_data.write_index !== want.write_index)
          report_mismatch("write_index", 64'(want.write_index), 64'(out_data.write_index));
        if (out_data.write_value !== want.write_value)
          report_mismatch("write_value", 64'(want.write_value), 64'(out_data.write_value));
        if (out_data.end_of_layout !== want.end_of_layout)
          report_mismatch("end_of_layout", 64'(want.end_of_layout),
                          64'(out_data.end_of_layout));
        if (out_data.overrun !== want.overrun)
          report_mismatch("overrun", 64'(want.overrun), 64'(out_data.overrun));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    bit mid_done;
    image_pos = 0;
    in_offsets = 1'b0;
    offsets_left = '0;
    offset_acc = '0;
    finished = 1'b0;
    reg_base = RST_REGISTER_BASE;
    reg_opcode = RST_LOAD_OPCODE;
    reg_posted = RST_POSTED_BIT;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset register values
    add_row(8'h00, 1, 1, 0, 32'h0000_0000, 1, 0);   // end right away
    add_row(8'h05, 0, 0, 0, 0, 0, 0);               // ignored after the end
    add_row(8'h40, 1, 1, 0, 32'hffff_ffff, 0, 0);   // restart, count zero, posted
    add_row(8'h01, 0, 1, 1, 32'h1100_0001, 0, 0);
    add_row(8'hff, 0, 0, 0, 0, 0, 0);
    add_row(8'h7f, 0, 1, 2, 32'h0000_fffc, 0, 0);
    add_row(8'h42, 0, 1, 4, 32'h1120_0003, 0, 0);
    add_row(8'h00, 0, 1, 5, 32'h0000_0000, 0, 0);   // zero offset byte
    repeat (4) add_row(8'hff, 0, 0, 0, 0, 0, 0);    // offset wider than 32 bits
    add_row(8'h7f, 0, 0, 0, 0, 0, 0);
    add_row(8'h80, 0, 0, 0, 0, 0, 0);               // skip of zero
    repeat (8) add_row(8'hff, 0, 0, 0, 0, 0, 0);    // position saturates
    add_row(8'h01, 0, 1, 0, 32'h1100_0001, 0, 1);
    add_row(8'h05, 0, 1, 0, 32'h0000_0014, 0, 1);
    add_row(8'h00, 0, 1, 0, 32'h0000_0000, 1, 0);
    foreach (layout_rows[i])
      send_word({layout_rows[i].b, layout_rows[i].sol}, layout_rows[i].typed,
                layout_rows[i].want);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      send_idle_pct = (p < 2) ? 8 : (p < 4) ? 72 : 0;
      recv_idle_pct = (p < 2) ? 72 : (p < 4) ? 8 : 0;
      if (p == 0) begin
        write_reg(REG_REGISTER_BASE, 32'h0);
        write_reg(REG_LOAD_OPCODE, 32'h0);
        write_reg(REG_POSTED_BIT, 32'h0);
      end else if (p == 1) begin
        write_reg(REG_REGISTER_BASE, 32'hffff_ffff);
        write_reg(REG_LOAD_OPCODE, 32'hffff_ffff);
        write_reg(REG_POSTED_BIT, 32'hffff_ffff);
      end else begin
        write_reg(REG_REGISTER_BASE, $urandom);
        write_reg(REG_LOAD_OPCODE, $urandom);
        write_reg(REG_POSTED_BIT, $urandom);
      end
      items_done = 0;
      mid_done = 1'b0;
      while (items_done < 300) begin
        if (!mid_done && items_done >= 150) begin
          mid_done = 1'b1;
          if (p == 1) hold_req++;
          if (p == 3) wait_idle();
        end
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 5))
            send_byte(8'($urandom), $urandom_range(0, 4) == 0);
        end else begin
          send_layout();
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
